### sv/vpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpd_pkg
// Shared types, register codes and reset values of the bus presence detector.
// ----------------------------------------------------------------------------
package vpd_pkg;

   localparam int ADC_BITS_DEF    = 12;
   localparam int MAX_SAMPLES_DEF = 16;

   localparam int MIN_SAMPLES  = 3;
   localparam int BUS_MV_MAX   = 6000;
   localparam int SCALE_W      = 20;
   localparam int Q_FRAC       = 16;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;
   localparam int RUN_W        = 8;

   localparam logic [12:0] ON_THR_RST  = 13'd3800;
   localparam logic [12:0] OFF_THR_RST = 13'd3200;
   localparam logic [7:0]  ON_CNT_RST  = 8'd3;
   localparam logic [7:0]  OFF_CNT_RST = 8'd3;
   localparam logic [4:0]  SPR_RST     = 5'd8;
   localparam logic [19:0] SCALE_RST   = 20'd134434;
   localparam logic [10:0] OFFSET_RST  = 11'd0;

   typedef enum logic [2:0] {
      REG_ON_THR,
      REG_OFF_THR,
      REG_ON_CNT,
      REG_OFF_CNT,
      REG_SPR,
      REG_SCALE,
      REG_OFFSET
   } reg_idx_type;

   typedef struct packed {
      logic [12:0]        on_threshold_mv;
      logic [12:0]        off_threshold_mv;
      logic [7:0]         on_count_needed;
      logic [7:0]         off_count_needed;
      logic [4:0]         samples_per_reading;
      logic [19:0]        scale_q16;
      logic signed [10:0] offset_mv;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

### sv/vpd_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpd_regs
// APB-style control register file holding thresholds, counts and calibration.
// ----------------------------------------------------------------------------
module vpd_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [vpd_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [vpd_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [vpd_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready,
   output vpd_pkg::cfg_type                    cfg
);

   vpd_pkg::cfg_type     cfg_ff;
   vpd_pkg::reg_idx_type idx;
   logic                 wr_en;

   assign csr_pready = 1'b1;
   assign idx        = vpd_pkg::reg_idx_type'(csr_paddr[vpd_pkg::CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.on_threshold_mv     <= vpd_pkg::ON_THR_RST;
         cfg_ff.off_threshold_mv    <= vpd_pkg::OFF_THR_RST;
         cfg_ff.on_count_needed     <= vpd_pkg::ON_CNT_RST;
         cfg_ff.off_count_needed    <= vpd_pkg::OFF_CNT_RST;
         cfg_ff.samples_per_reading <= vpd_pkg::SPR_RST;
         cfg_ff.scale_q16           <= vpd_pkg::SCALE_RST;
         cfg_ff.offset_mv           <= vpd_pkg::OFFSET_RST;
      end else if (wr_en) begin
         case (idx)
            vpd_pkg::REG_ON_THR:  cfg_ff.on_threshold_mv     <= csr_pwdata[12:0];
            vpd_pkg::REG_OFF_THR: cfg_ff.off_threshold_mv    <= csr_pwdata[12:0];
            vpd_pkg::REG_ON_CNT:  cfg_ff.on_count_needed     <= csr_pwdata[7:0];
            vpd_pkg::REG_OFF_CNT: cfg_ff.off_count_needed    <= csr_pwdata[7:0];
            vpd_pkg::REG_SPR:     cfg_ff.samples_per_reading <= csr_pwdata[4:0];
            vpd_pkg::REG_SCALE:   cfg_ff.scale_q16           <= csr_pwdata[19:0];
            vpd_pkg::REG_OFFSET:  cfg_ff.offset_mv           <= csr_pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         vpd_pkg::REG_ON_THR:  csr_prdata = 32'(cfg_ff.on_threshold_mv);
         vpd_pkg::REG_OFF_THR: csr_prdata = 32'(cfg_ff.off_threshold_mv);
         vpd_pkg::REG_ON_CNT:  csr_prdata = 32'(cfg_ff.on_count_needed);
         vpd_pkg::REG_OFF_CNT: csr_prdata = 32'(cfg_ff.off_count_needed);
         vpd_pkg::REG_SPR:     csr_prdata = 32'(cfg_ff.samples_per_reading);
         vpd_pkg::REG_SCALE:   csr_prdata = 32'(cfg_ff.scale_q16);
         vpd_pkg::REG_OFFSET:  csr_prdata = 32'(unsigned'(cfg_ff.offset_mv));
         default:              csr_prdata = '0;
      endcase
   end

endmodule

### sv/vpd_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpd_accum
// Group accumulator: running sum, minimum and maximum of one reading.
// ----------------------------------------------------------------------------
module vpd_accum #(
   parameter int ADC_BITS    = vpd_pkg::ADC_BITS_DEF,
   parameter int MAX_SAMPLES = vpd_pkg::MAX_SAMPLES_DEF,
   parameter int CW          = $clog2(MAX_SAMPLES + 1),
   parameter int SW          = ADC_BITS + CW
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                sample_en,
   input  logic [ADC_BITS-1:0] sample,
   input  logic [4:0]          samples_per_reading,
   output logic                grp_done,
   output logic [SW-1:0]       numerator,
   output logic [CW-1:0]       divisor
);

   logic [CW-1:0]       count_ff, count_in, cnt_nx;
   logic [SW-1:0]       sum_ff, sum_in, base_sum;
   logic [ADC_BITS-1:0] min_ff, min_in, base_min;
   logic [ADC_BITS-1:0] max_ff, max_in, base_max;
   logic [CW-1:0]       divisor_ff, divisor_in;
   logic [7:0]          spr8, n8;
   logic                first;

   // effective group size, clamped to the supported range
   always_comb begin
      spr8 = 8'(samples_per_reading);
      if (spr8 < 8'(vpd_pkg::MIN_SAMPLES)) begin
         n8 = 8'(vpd_pkg::MIN_SAMPLES);
      end else if (spr8 > 8'(MAX_SAMPLES)) begin
         n8 = 8'(MAX_SAMPLES);
      end else begin
         n8 = spr8;
      end
   end

   always_comb begin
      first      = (count_ff == '0);
      base_sum   = first ? '0 : sum_ff;
      base_min   = first ? sample : min_ff;
      base_max   = first ? sample : max_ff;
      sum_in     = base_sum + SW'(sample);
      min_in     = (sample < base_min) ? sample : base_min;
      max_in     = (sample > base_max) ? sample : base_max;
      cnt_nx     = count_ff + CW'(1);
      divisor_in = cnt_nx - CW'(2);
      grp_done   = sample_en && (8'(cnt_nx) >= n8);
      if (!sample_en) begin
         count_in = count_ff;
      end else if (grp_done) begin
         count_in = '0;
      end else begin
         count_in = cnt_nx;
      end
   end

   assign numerator = sum_ff - SW'(min_ff) - SW'(max_ff);
   assign divisor   = divisor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      if (sample_en) begin
         sum_ff     <= sum_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         divisor_ff <= divisor_in;
      end
   end

endmodule

### sv/vpd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpd_div
// Serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vpd_div #(
   parameter int SW = vpd_pkg::ADC_BITS_DEF + 5,
   parameter int CW = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [SW-1:0]         dividend,
   input  logic [CW-1:0]         divisor,
   output vpd_pkg::div_stat_type stat,
   output logic [SW-1:0]         quotient
);

   localparam int KW = $clog2(SW + 1);

   logic [SW-1:0] q_ff, q_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [CW-1:0] d_ff;
   logic [KW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [CW:0]   rem_sh;

   always_comb begin
      rem_sh  = {rem_ff, q_ff[SW-1]};
      q_in    = q_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         q_in   = dividend;
         rem_in = '0;
         cnt_in = KW'(SW);
      end else if (cnt_ff != '0) begin
         if (rem_sh >= {1'b0, d_ff}) begin
            rem_in = CW'(rem_sh - {1'b0, d_ff});
            q_in   = {q_ff[SW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[CW-1:0];
            q_in   = {q_ff[SW-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - KW'(1);
         done_in = (cnt_ff == KW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      if (start) begin
         d_ff <= divisor;
      end
   end

   assign stat.busy = (cnt_ff != '0);
   assign stat.done = done_ff;
   assign quotient  = q_ff;

endmodule

### sv/vbus_presence_detector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbus_presence_detector_unit
// Trimmed-mean bus voltage estimator with hysteresis and debounced presence.
// ----------------------------------------------------------------------------
// The first sample after reset is dropped as warm-up. A sample that does not
// complete a reading is taken at once and the next can follow straight away.
// The sample that completes a reading holds off the input while the block
// steps through start, divide, multiply, scale and result states: the serial
// divider forms the trimmed mean one quotient bit per cycle, followed by the
// Q16 multiply, the offset and clamp, and the debounce update. A finished
// result waits in the output register until taken; the input channel stays
// open meanwhile, and only the next completed reading waits for that register
// to free up.
module vbus_presence_detector_unit #(
   parameter int ADC_BITS    = vpd_pkg::ADC_BITS_DEF,
   parameter int MAX_SAMPLES = vpd_pkg::MAX_SAMPLES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ADC_BITS-1:0]            req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_present,
   output logic [12:0]                    rsp_bus_mv,
   output logic [ADC_BITS-1:0]            rsp_mean_count,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [vpd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [vpd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [vpd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int SW = ADC_BITS + CW;
   localparam int PW = ADC_BITS + vpd_pkg::SCALE_W;
   localparam int MW = PW - vpd_pkg::Q_FRAC + 2;
   localparam int RW = vpd_pkg::RUN_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_MUL,
      ST_SCALE,
      ST_OUT
   } state_type;

   vpd_pkg::cfg_type      cfg;
   vpd_pkg::div_stat_type div_stat;

   state_type           state_ff, state_in;
   logic                warmed_ff, warmed_in;
   logic                present_ff, present_in;
   logic [RW-1:0]       high_run_ff, high_run_in, high_inc;
   logic [RW-1:0]       low_run_ff, low_run_in, low_inc;
   logic [ADC_BITS-1:0] mean_ff, mean_in;
   logic [PW-1:0]       prod_ff, prod_in;
   logic [12:0]         mv_ff, mv_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_present_ff, rsp_present_in;
   logic [12:0]         rsp_bus_mv_ff, rsp_bus_mv_in;
   logic [ADC_BITS-1:0] rsp_mean_ff, rsp_mean_in;

   logic                accept, sample_en, grp_done, div_start, out_free;
   logic [SW-1:0]       numerator, quotient;
   logic [CW-1:0]       divisor;
   logic [PW-1:0]       rnd_sum;
   logic signed [10:0]  offset_s;
   logic signed [MW-1:0] mv_s;

   vpd_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   vpd_accum #(
      .ADC_BITS    (ADC_BITS),
      .MAX_SAMPLES (MAX_SAMPLES),
      .CW          (CW),
      .SW          (SW)
   ) u_accum (
      .clock               (clock),
      .reset               (reset),
      .sample_en           (sample_en),
      .sample              (req_sample),
      .samples_per_reading (cfg.samples_per_reading),
      .grp_done            (grp_done),
      .numerator           (numerator),
      .divisor             (divisor)
   );

   vpd_div #(
      .SW (SW),
      .CW (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (numerator),
      .divisor  (divisor),
      .stat     (div_stat),
      .quotient (quotient)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign sample_en = accept && warmed_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign div_start = (state_ff == ST_START);

   // Q16 product rounded half up, offset applied in signed arithmetic
   assign offset_s = cfg.offset_mv;
   assign rnd_sum  = prod_ff + PW'(1 << (vpd_pkg::Q_FRAC - 1));
   assign mv_s     = signed'({2'b00, rnd_sum[PW-1:vpd_pkg::Q_FRAC]}) + MW'(offset_s);

   assign high_inc = (high_run_ff == '1) ? high_run_ff : high_run_ff + RW'(1);
   assign low_inc  = (low_run_ff == '1) ? low_run_ff : low_run_ff + RW'(1);

   always_comb begin
      state_in       = state_ff;
      warmed_in      = warmed_ff | accept;
      present_in     = present_ff;
      high_run_in    = high_run_ff;
      low_run_in     = low_run_ff;
      mean_in        = mean_ff;
      prod_in        = prod_ff;
      mv_in          = mv_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_present_in = rsp_present_ff;
      rsp_bus_mv_in  = rsp_bus_mv_ff;
      rsp_mean_in    = rsp_mean_ff;

      case (state_ff)
         ST_IDLE: begin
            if (sample_en && grp_done) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               mean_in  = quotient[ADC_BITS-1:0];
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PW'(mean_ff) * PW'(cfg.scale_q16);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (mv_s[MW-1]) begin
               mv_in = '0;
            end else if (mv_s[MW-2:0] > (MW-1)'(vpd_pkg::BUS_MV_MAX)) begin
               mv_in = 13'(vpd_pkg::BUS_MV_MAX);
            end else begin
               mv_in = mv_s[12:0];
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               if (!present_ff) begin
                  if (mv_ff >= cfg.on_threshold_mv) begin
                     high_run_in = high_inc;
                     if (high_inc >= cfg.on_count_needed) begin
                        present_in = 1'b1;
                        low_run_in = '0;
                     end
                  end else begin
                     high_run_in = '0;
                  end
               end else begin
                  if (mv_ff <= cfg.off_threshold_mv) begin
                     low_run_in = low_inc;
                     if (low_inc >= cfg.off_count_needed) begin
                        present_in  = 1'b0;
                        high_run_in = '0;
                     end
                  end else begin
                     low_run_in = '0;
                  end
               end
               rsp_valid_in   = 1'b1;
               rsp_present_in = present_in;
               rsp_bus_mv_in  = mv_ff;
               rsp_mean_in    = mean_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         warmed_ff    <= 1'b0;
         present_ff   <= 1'b0;
         high_run_ff  <= '0;
         low_run_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         warmed_ff    <= warmed_in;
         present_ff   <= present_in;
         high_run_ff  <= high_run_in;
         low_run_ff   <= low_run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mean_ff        <= mean_in;
      prod_ff        <= prod_in;
      mv_ff          <= mv_in;
      rsp_present_ff <= rsp_present_in;
      rsp_bus_mv_ff  <= rsp_bus_mv_in;
      rsp_mean_ff    <= rsp_mean_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_present    = rsp_present_ff;
   assign rsp_bus_mv     = rsp_bus_mv_ff;
   assign rsp_mean_count = rsp_mean_ff;

   // a new transaction appears only out of the result state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside result state");

   // the divider is quiet whenever samples are being taken
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_stat.busy)
      else $error("divider busy while accepting samples");

   // clamp keeps the estimate within the bus range
   a_mv_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> (mv_ff <= 13'(vpd_pkg::BUS_MV_MAX)))
      else $error("bus voltage estimate out of range");

   // presence only changes when a result is loaded
   a_present_step: assert property (@(posedge clock) disable iff (reset)
      (present_ff != $past(present_ff)) |-> $rose(rsp_valid_ff) || $past(rsp_valid_ff))
      else $error("presence changed without a result");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bus presence detector. Raw samples stream in
// through a bursty driver, each accepted sample feeds an in-bench predictor
// of the trimmed mean, millivolt scaling and debounced presence flag, and a
// monitor under random backpressure compares every reading field by field.
// Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

   localparam int ADC_W         = vpd_pkg::ADC_BITS_DEF;
   localparam int ITEM_GOAL     = 1850;
   localparam int SETTLE_CYCLES = 40;
   localparam int QUIET_LIMIT   = 3000;

   typedef struct {
      logic        present;
      logic [12:0] bus_mv;
      logic [11:0] mean_count;
   } reading_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [ADC_W-1:0]               req_sample = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic                           rsp_present;
   logic [12:0]                    rsp_bus_mv;
   logic [ADC_W-1:0]               rsp_mean_count;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [vpd_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [vpd_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [vpd_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   vbus_presence_detector_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_present    (rsp_present),
      .rsp_bus_mv     (rsp_bus_mv),
      .rsp_mean_count (rsp_mean_count),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // predictor state and register copy
   vpd_pkg::cfg_type det_cfg;
   logic             warm_done;
   int               grp_cnt;
   logic [15:0]      grp_sum;
   logic [11:0]      grp_min;
   logic [11:0]      grp_max;
   logic [7:0]       high_run;
   logic [7:0]       low_run;
   logic             present_flag;

   reading_type      pending_readings[$];
   logic [ADC_W-1:0] sample_backlog[$];
   int               items_sent = 0;
   int               error_count = 0;
   int               idle_cycles = 0;

   int          burst_left = 1;
   int          gap_left = 0;
   logic [15:0] stall_pattern = '0;
   int          stall_timer = 0;

   function automatic int group_target();
      int n;
      n = det_cfg.samples_per_reading;
      if (n < vpd_pkg::MIN_SAMPLES) n = vpd_pkg::MIN_SAMPLES;
      if (n > vpd_pkg::MAX_SAMPLES_DEF) n = vpd_pkg::MAX_SAMPLES_DEF;
      return n;
   endfunction

   function automatic void predict_reading(logic [11:0] s);
      int     mean;
      longint mv;
      reading_type r;
      if (!warm_done) begin
         warm_done = 1'b1;
         return;
      end
      if (grp_cnt == 0) begin
         grp_sum = '0;
         grp_min = s;
         grp_max = s;
      end
      grp_sum = grp_sum + s;
      if (s < grp_min) grp_min = s;
      if (s > grp_max) grp_max = s;
      grp_cnt++;
      if (grp_cnt < group_target()) return;

      mean = (int'(grp_sum) - int'(grp_min) - int'(grp_max)) / (grp_cnt - 2);
      grp_cnt = 0;
      grp_sum = '0;

      // Q16 product rounded half up, then offset and clamp
      mv = (longint'(mean) * longint'(det_cfg.scale_q16) + 32768) >>> vpd_pkg::Q_FRAC;
      mv = mv + longint'(det_cfg.offset_mv);
      if (mv < 0) mv = 0;
      if (mv > vpd_pkg::BUS_MV_MAX) mv = vpd_pkg::BUS_MV_MAX;

      if (!present_flag) begin
         if (mv >= det_cfg.on_threshold_mv) begin
            if (high_run != 8'd255) high_run++;
            if (high_run >= det_cfg.on_count_needed) begin
               present_flag = 1'b1;
               low_run = '0;
            end
         end else begin
            high_run = '0;
         end
      end else begin
         if (mv <= det_cfg.off_threshold_mv) begin
            if (low_run != 8'd255) low_run++;
            if (low_run >= det_cfg.off_count_needed) begin
               present_flag = 1'b0;
               high_run = '0;
            end
         end else begin
            low_run = '0;
         end
      end

      r.present    = present_flag;
      r.bus_mv     = 13'(mv);
      r.mean_count = 12'(mean);
      pending_readings.push_back(r);
   endfunction

   function automatic int pick_gap();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 0;
         4, 5, 6, 7: return $urandom_range(1, 4);
         8:          return $urandom_range(5, 30);
         default:    return $urandom_range(20, 60);
      endcase
   endfunction

   // driver: bursts of samples with random gaps, payload held while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_reading(req_sample);
         if (req_valid && req_stall) begin
            req_valid <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (sample_backlog.size() > 0) begin
            req_valid  <= 1'b1;
            req_sample <= sample_backlog.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= pick_gap();
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   task automatic report_mismatch(string what, longint got, longint want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // monitor: stall pattern of its own, checks each result transaction
   always @(posedge clock) begin
      reading_type want;
      rsp_stall <= stall_pattern[0];
      if (stall_timer == 0) begin
         stall_timer <= $urandom_range(50, 300);
         case ($urandom_range(0, 3))
            0:       stall_pattern <= '0;
            1:       stall_pattern <= 16'hFFFE;
            default: stall_pattern <= 16'($urandom) & 16'hFFFE;
         endcase
      end else begin
         stall_timer   <= stall_timer - 1;
         stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      end

      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;

      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            report_mismatch("unexpected reading, mean_count", rsp_mean_count, -1);
         end else begin
            want = pending_readings.pop_front();
            if (rsp_present !== want.present)
               report_mismatch("present", rsp_present, want.present);
            if (rsp_bus_mv !== want.bus_mv)
               report_mismatch("bus_mv", rsp_bus_mv, want.bus_mv);
            if (rsp_mean_count !== want.mean_count)
               report_mismatch("mean_count", rsp_mean_count, want.mean_count);
         end
      end
   end

   initial begin
      while (idle_cycles < QUIET_LIMIT) @(negedge clock);
      $display("** vbus_presence_detector_unit: FAILED **");
      $finish;
   end

   task automatic csr_write(vpd_pkg::reg_idx_type idx, int unsigned value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= vpd_pkg::CSR_ADDR_W'(int'(idx) * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         vpd_pkg::REG_ON_THR:  det_cfg.on_threshold_mv     = value[12:0];
         vpd_pkg::REG_OFF_THR: det_cfg.off_threshold_mv    = value[12:0];
         vpd_pkg::REG_ON_CNT:  det_cfg.on_count_needed     = value[7:0];
         vpd_pkg::REG_OFF_CNT: det_cfg.off_count_needed    = value[7:0];
         vpd_pkg::REG_SPR:     det_cfg.samples_per_reading = value[4:0];
         vpd_pkg::REG_SCALE:   det_cfg.scale_q16           = value[19:0];
         vpd_pkg::REG_OFFSET:  det_cfg.offset_mv           = value[10:0];
         default: ;
      endcase
   endtask

   task automatic push_sample(int s);
      sample_backlog.push_back(ADC_W'(s));
      items_sent++;
   endtask

   // wait until every sample is taken and every reading checked
   task automatic finish_phase();
      @(negedge clock);
      while (sample_backlog.size() != 0 || req_valid || pending_readings.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic int count_for_mv(int mv);
      longint c;
      if (det_cfg.scale_q16 == 0) return $urandom_range(0, 4095);
      c = (longint'(mv - int'(det_cfg.offset_mv)) <<< vpd_pkg::Q_FRAC)
          / longint'(det_cfg.scale_q16);
      if (c < 0) c = 0;
      if (c > 4095) c = 4095;
      return int'(c);
   endfunction

   task automatic randomize_config();
      int on_thr;
      int off_thr;
      on_thr = det_cfg.on_threshold_mv;
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 9))
            0:       on_thr = 0;
            1:       on_thr = vpd_pkg::BUS_MV_MAX;
            2:       on_thr = 8191;
            default: on_thr = $urandom_range(1000, 5500);
         endcase
         csr_write(vpd_pkg::REG_ON_THR, on_thr);
      end
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 9))
            0:       off_thr = 0;
            1:       off_thr = vpd_pkg::BUS_MV_MAX;
            2:       off_thr = $urandom_range(0, 8191);
            default: off_thr = on_thr - int'($urandom_range(0, 800));
         endcase
         if (off_thr < 0) off_thr = 0;
         csr_write(vpd_pkg::REG_OFF_THR, off_thr);
      end
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 9))
            0:       csr_write(vpd_pkg::REG_ON_CNT, 0);
            1:       csr_write(vpd_pkg::REG_ON_CNT, 255);
            default: csr_write(vpd_pkg::REG_ON_CNT, $urandom_range(1, 5));
         endcase
      end
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 9))
            0:       csr_write(vpd_pkg::REG_OFF_CNT, 0);
            1:       csr_write(vpd_pkg::REG_OFF_CNT, 255);
            default: csr_write(vpd_pkg::REG_OFF_CNT, $urandom_range(1, 5));
         endcase
      end
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 9))
            0:       csr_write(vpd_pkg::REG_SPR, $urandom_range(0, 2));
            1:       csr_write(vpd_pkg::REG_SPR, $urandom_range(17, 31));
            2:       csr_write(vpd_pkg::REG_SPR, vpd_pkg::MAX_SAMPLES_DEF);
            default: csr_write(vpd_pkg::REG_SPR, $urandom_range(3, 8));
         endcase
      end
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 9))
            0:       csr_write(vpd_pkg::REG_SCALE, 0);
            1:       csr_write(vpd_pkg::REG_SCALE, 20'hFFFFF);
            2:       csr_write(vpd_pkg::REG_SCALE, $urandom_range(0, 20'hFFFFF));
            default: csr_write(vpd_pkg::REG_SCALE, $urandom_range(100000, 200000));
         endcase
      end
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 9))
            0:       csr_write(vpd_pkg::REG_OFFSET, 11'h400);
            1:       csr_write(vpd_pkg::REG_OFFSET, 11'h3FF);
            2:       csr_write(vpd_pkg::REG_OFFSET, 11'($urandom_range(0, 2000) - 1000));
            default: csr_write(vpd_pkg::REG_OFFSET, 11'($urandom_range(0, 200) - 100));
         endcase
      end
   endtask

   // groups of readings held at one level for a run, so the debounce
   // counters reach their limits; a few stray samples shift group alignment
   task automatic random_phase();
      int groups;
      int per_group;
      int level;
      int run_left;
      int target;
      int base;
      int s;
      randomize_config();
      per_group = group_target();
      groups    = $urandom_range(3, 20);
      run_left  = 0;
      level     = 0;
      for (int g = 0; g < groups; g++) begin
         if (run_left == 0) begin
            level    = $urandom_range(0, 5);
            run_left = $urandom_range(1, 6);
         end
         run_left--;
         case (level)
            0, 1:    target = det_cfg.on_threshold_mv + $urandom_range(0, 200);
            2:       target = int'(det_cfg.off_threshold_mv) - int'($urandom_range(0, 200));
            3:       target = (det_cfg.on_threshold_mv + det_cfg.off_threshold_mv) / 2;
            default: target = $urandom_range(0, 1) ? det_cfg.on_threshold_mv
                                                   : det_cfg.off_threshold_mv;
         endcase
         base = count_for_mv(target);
         for (int i = 0; i < per_group; i++) begin
            if (level == 5 || $urandom_range(0, 9) == 0) begin
               s = $urandom_range(0, 4095);
            end else begin
               s = base + int'($urandom_range(0, 8)) - 4;
               if (s < 0) s = 0;
               if (s > 4095) s = 4095;
            end
            push_sample(s);
         end
         if ($urandom_range(0, 15) == 0) begin
            repeat ($urandom_range(1, 2)) push_sample($urandom_range(0, 4095));
         end
      end
      finish_phase();
   endtask

   initial begin
      det_cfg.on_threshold_mv     = vpd_pkg::ON_THR_RST;
      det_cfg.off_threshold_mv    = vpd_pkg::OFF_THR_RST;
      det_cfg.on_count_needed     = vpd_pkg::ON_CNT_RST;
      det_cfg.off_count_needed    = vpd_pkg::OFF_CNT_RST;
      det_cfg.samples_per_reading = vpd_pkg::SPR_RST;
      det_cfg.scale_q16           = vpd_pkg::SCALE_RST;
      det_cfg.offset_mv           = vpd_pkg::OFFSET_RST;
      warm_done    = 1'b0;
      grp_cnt      = 0;
      grp_sum      = '0;
      grp_min      = '0;
      grp_max      = '0;
      high_run     = '0;
      low_run      = '0;
      present_flag = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // warm-up sample, then one reading at reset settings with bit patterns
      push_sample(4095);
      push_sample(12'h000);
      push_sample(12'hFFF);
      push_sample(12'hAAA);
      push_sample(12'h555);
      push_sample(12'h800);
      push_sample(12'h7FF);
      push_sample(12'h001);
      push_sample(12'hFFE);
      finish_phase();

      // size below range, zero counts, full-scale gain, negative offset limit
      csr_write(vpd_pkg::REG_ON_THR, vpd_pkg::BUS_MV_MAX);
      csr_write(vpd_pkg::REG_OFF_THR, 0);
      csr_write(vpd_pkg::REG_ON_CNT, 0);
      csr_write(vpd_pkg::REG_OFF_CNT, 0);
      csr_write(vpd_pkg::REG_SPR, 2);
      csr_write(vpd_pkg::REG_SCALE, 20'hFFFFF);
      csr_write(vpd_pkg::REG_OFFSET, 11'h400);
      @(negedge clock);
      repeat (3) push_sample(4095);
      repeat (3) push_sample(0);
      finish_phase();

      // size above range, then shrunk while a group is partly filled
      csr_write(vpd_pkg::REG_SPR, 31);
      @(negedge clock);
      push_sample(100);
      push_sample(4095);
      push_sample(0);
      push_sample(2000);
      push_sample(3000);
      finish_phase();
      csr_write(vpd_pkg::REG_SPR, 4);
      @(negedge clock);
      push_sample(1234);
      finish_phase();

      while (items_sent < ITEM_GOAL) random_phase();

      if (error_count == 0)
         $display("** vbus_presence_detector_unit: PASSED **");
      else
         $display("** vbus_presence_detector_unit: FAILED **");
      $finish;
   end

endmodule

### sim.f
sv/vpd_pkg.sv
sv/vpd_regs.sv
sv/vpd_accum.sv
sv/vpd_div.sv
sv/vbus_presence_detector_unit.sv
test/testbench.sv
